// ===== rtl/core/lsbp_pkg.sv =====
// Shared types and constants for the line sensor bar position block.
package lsbp_pkg;

   // Default configuration of the sensor bar.
   localparam int NUM_CHANNELS_DEF = 16;
   localparam int SAMPLE_BITS_DEF  = 10;
   localparam int WEIGHT_STEP_DEF  = 100;

   // Fixed field widths of the request and response transactions.
   localparam int FUNC_W       = 2;
   localparam int CHANNEL_W    = 4;
   localparam int SAMPLE_W     = 10;
   localparam int POSITION_W   = 11;
   localparam int ACT_COUNT_W  = 5;
   localparam int LINE_BITS_W  = 16;

   // Saturation limits of the response fields.
   localparam int unsigned POS_MAX   = 2047;
   localparam int unsigned COUNT_MAX = 31;

   // Register port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Word index of the polarity register (byte address 0).
   localparam logic CSR_IDX_WHITE_LINE_MODE = 1'b0;

   // Operation carried by a request transaction.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_STORE_WHITE = 2'd0,
      FUNC_STORE_BLACK = 2'd1,
      FUNC_LATCH       = 2'd2,
      FUNC_MEASURE     = 2'd3
   } func_type;

   typedef struct packed {
      func_type              func;
      logic [CHANNEL_W-1:0]  channel;
      logic [SAMPLE_W-1:0]   sample;
   } req_type;

   typedef struct packed {
      logic [POSITION_W-1:0]  position;
      logic [ACT_COUNT_W-1:0] active_count;
      logic                   no_line;
      logic [LINE_BITS_W-1:0] line_bits;
   } rsp_type;

endpackage

// ===== rtl/core/line_sensor_bar_position.sv =====
// Line sensor bar: per-channel calibration, line detection and centroid position.
// Store items are written straight from idle; latch and measure items run the bit-serial
// add/compare over the sample bits and then return to idle.
// A last-channel measure then accumulates over all NUM_CHANNELS, divides over SUM_W bits
// and registers the response; that output step waits while an earlier response stalls.
// One item at a time; synchronous active-high reset clears stores, polarity and control.
module line_sensor_bar_position
   import lsbp_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int WEIGHT_STEP  = WEIGHT_STEP_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CH_W       = $clog2(NUM_CHANNELS);
   localparam int CNT_W      = $clog2(NUM_CHANNELS + 1);
   localparam int SUM_MAX    = WEIGHT_STEP * NUM_CHANNELS * (NUM_CHANNELS - 1) / 2;
   localparam int SUM_W_RAW  = $clog2(SUM_MAX + 1);
   localparam int SUM_W      = (SUM_W_RAW < 2) ? 2 : SUM_W_RAW;
   localparam int SCNT_W     = $clog2(SAMPLE_BITS);
   localparam int DCNT_W     = $clog2(SUM_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SERIAL,
      ST_ACCUM,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Control registers.
   state_type              state_ff, state_in;
   logic                   mode_ff, mode_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_payload_ff, rsp_payload_in;

   // Datapath registers.
   logic                   op_latch_ff, op_latch_in;
   logic [CH_W-1:0]        ch_ff, ch_in;
   logic [SAMPLE_BITS-1:0] sa_ff, sa_in;
   logic [SAMPLE_BITS-1:0] sb_ff, sb_in;
   logic [SAMPLE_BITS-1:0] res_ff, res_in;
   logic                   carry_ff, carry_in;
   logic [SCNT_W-1:0]      ser_cnt_ff, ser_cnt_in;
   logic [CH_W-1:0]        acc_cnt_ff, acc_cnt_in;
   logic [SUM_W-1:0]       weight_ff, weight_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [DCNT_W-1:0]      div_cnt_ff, div_cnt_in;

   // Per-channel stores.
   logic [SAMPLE_BITS-1:0] white_ff [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] black_ff [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] thr_ff   [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] line_bit_ff;

   // Store write controls.
   logic                   wr_white, wr_black, wr_thr, wr_line;
   logic [SAMPLE_BITS-1:0] thr_value;
   logic                   line_value;

   // Combinational helpers.
   logic                   req_accept;
   logic                   ch_in_range;
   logic [CH_W-1:0]        req_ch;
   logic [SAMPLE_BITS-1:0] req_smp;
   logic                   bit_a, bit_b, sum_bit, carry_out;
   logic [SAMPLE_BITS-1:0] res_next;
   logic                   ser_last;
   logic [CNT_W:0]         trial;
   logic [CNT_W:0]         den_ext;
   logic                   q_bit;
   logic                   out_free;
   logic                   csr_write;
   logic [LINE_BITS_W-1:0] line_bits_view;
   rsp_type                frame;

   // Ports.
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_pready  = 1'b1;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata  = (csr_paddr[2] == CSR_IDX_WHITE_LINE_MODE)
                        ? {{(CSR_DATA_W-1){1'b0}}, mode_ff} : '0;

   // Request decode.
   assign req_accept  = req_valid && !req_stall;
   assign ch_in_range = (32'(req_payload.channel) < NUM_CHANNELS);
   assign req_ch      = CH_W'(req_payload.channel);
   assign req_smp     = SAMPLE_BITS'(req_payload.sample);

   // Bit-serial add (latch) or subtract borrow chain (measure), LSB first.
   assign bit_a     = sa_ff[0];
   assign bit_b     = sb_ff[0];
   assign sum_bit   = bit_a ^ bit_b ^ carry_ff;
   assign carry_out = op_latch_ff ? ((bit_a & bit_b) | (carry_ff & (bit_a ^ bit_b)))
                                  : ((~bit_a & bit_b) | (~(bit_a ^ bit_b) & carry_ff));
   assign res_next   = {sum_bit, res_ff[SAMPLE_BITS-1:1]};
   assign ser_last   = (ser_cnt_ff == SCNT_W'(SAMPLE_BITS - 1));
   assign thr_value  = {carry_out, res_next[SAMPLE_BITS-1:1]};
   // A final borrow means the sample lies below the threshold.
   assign line_value = mode_ff ? carry_out : ~carry_out;

   // Restoring division step: one quotient bit per cycle.
   assign den_ext = {1'b0, count_ff};
   assign trial   = {rem_ff, sum_ff[SUM_W-1]};
   assign q_bit   = (trial >= den_ext);

   // Line bits as seen on the response, channel i on bit i.
   for (genvar gi = 0; gi < LINE_BITS_W; gi++) begin : g_line_bits
      if (gi < NUM_CHANNELS) begin : g_used
         assign line_bits_view[gi] = line_bit_ff[gi];
      end else begin : g_unused
         assign line_bits_view[gi] = 1'b0;
      end
   end

   // Frame result, with saturation and the no-line case.
   always_comb begin
      frame.line_bits    = line_bits_view;
      frame.no_line      = (count_ff == '0);
      frame.active_count = (32'(count_ff) > COUNT_MAX) ? ACT_COUNT_W'(COUNT_MAX)
                                                       : ACT_COUNT_W'(count_ff);
      if (count_ff == '0) begin
         frame.position = '0;
      end else if (32'(sum_ff) > POS_MAX) begin
         frame.position = POSITION_W'(POS_MAX);
      end else begin
         frame.position = POSITION_W'(sum_ff);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      op_latch_in    = op_latch_ff;
      ch_in          = ch_ff;
      sa_in          = sa_ff;
      sb_in          = sb_ff;
      res_in         = res_ff;
      carry_in       = carry_ff;
      ser_cnt_in     = ser_cnt_ff;
      acc_cnt_in     = acc_cnt_ff;
      weight_in      = weight_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      wr_white       = 1'b0;
      wr_black       = 1'b0;
      wr_thr         = 1'b0;
      wr_line        = 1'b0;

      // Polarity register write.
      if (csr_write && (csr_paddr[2] == CSR_IDX_WHITE_LINE_MODE)) begin
         mode_in = csr_pwdata[0];
      end

      // The response register empties when its transaction completes.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && ch_in_range) begin
               ch_in      = req_ch;
               carry_in   = 1'b0;
               ser_cnt_in = '0;
               case (req_payload.func)
                  FUNC_STORE_WHITE: begin
                     wr_white = 1'b1;
                  end
                  FUNC_STORE_BLACK: begin
                     wr_black = 1'b1;
                  end
                  FUNC_LATCH: begin
                     sa_in       = white_ff[req_ch];
                     sb_in       = black_ff[req_ch];
                     op_latch_in = 1'b1;
                     state_in    = ST_SERIAL;
                  end
                  FUNC_MEASURE: begin
                     sa_in       = req_smp;
                     sb_in       = thr_ff[req_ch];
                     op_latch_in = 1'b0;
                     state_in    = ST_SERIAL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SERIAL: begin
            sa_in      = sa_ff >> 1;
            sb_in      = sb_ff >> 1;
            res_in     = res_next;
            carry_in   = carry_out;
            ser_cnt_in = ser_cnt_ff + 1'b1;
            if (ser_last) begin
               if (op_latch_ff) begin
                  wr_thr   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  wr_line = 1'b1;
                  if (ch_ff == CH_W'(NUM_CHANNELS - 1)) begin
                     acc_cnt_in = '0;
                     weight_in  = SUM_W'(WEIGHT_STEP * (NUM_CHANNELS - 1));
                     sum_in     = '0;
                     count_in   = '0;
                     state_in   = ST_ACCUM;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_ACCUM: begin
            // One channel per cycle; its weight steps down as the channel rises.
            if (line_bit_ff[acc_cnt_ff]) begin
               sum_in   = sum_ff + weight_ff;
               count_in = count_ff + 1'b1;
            end
            weight_in  = weight_ff - SUM_W'(WEIGHT_STEP);
            acc_cnt_in = acc_cnt_ff + 1'b1;
            if (acc_cnt_ff == CH_W'(NUM_CHANNELS - 1)) begin
               rem_in     = '0;
               div_cnt_in = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // The dividend shifts out of sum_ff while the quotient shifts in.
            if (q_bit) begin
               rem_in = CNT_W'(trial - den_ext);
            end else begin
               rem_in = CNT_W'(trial);
            end
            sum_in     = {sum_ff[SUM_W-2:0], q_bit};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DCNT_W'(SUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = frame;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, polarity register and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   // Serial datapath registers.
   always_ff @(posedge clock) begin
      op_latch_ff <= op_latch_in;
      ch_ff       <= ch_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      res_ff      <= res_in;
      carry_ff    <= carry_in;
      ser_cnt_ff  <= ser_cnt_in;
      acc_cnt_ff  <= acc_cnt_in;
      weight_ff   <= weight_in;
      sum_ff      <= sum_in;
      count_ff    <= count_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
   end

   // Calibration, threshold and line bit stores, all cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            white_ff[i] <= '0;
            black_ff[i] <= '0;
            thr_ff[i]   <= '0;
         end
         line_bit_ff <= '0;
      end else begin
         if (wr_white) begin
            white_ff[ch_in] <= req_smp;
         end
         if (wr_black) begin
            black_ff[ch_in] <= req_smp;
         end
         if (wr_thr) begin
            thr_ff[ch_ff] <= thr_value;
         end
         if (wr_line) begin
            line_bit_ff[ch_ff] <= line_value;
         end
      end
   end

endmodule

// ===== rtl/core/lsbp_checker.sv =====
// Port-level assertions for the line sensor bar position block, with its bind.
module lsbp_checker
   import lsbp_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // A stalled response transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // A measure of the last channel keeps the block busy for the frame computation.
   a_frame_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.func == FUNC_MEASURE)
      && (32'(req_payload.channel) == NUM_CHANNELS - 1) |=> req_stall)
      else $error("block not busy after last-channel measure");

   // The no-line flag agrees with the active count, and forces a zero position and zero line bits.
   a_no_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.no_line == (rsp_payload.active_count == '0))
      && (!rsp_payload.no_line || (rsp_payload.position == '0
      && rsp_payload.line_bits == '0)))
      else $error("no-line flag inconsistent with response fields");

   // A new response only appears at the end of a busy period.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without frame computation");

endmodule

bind line_sensor_bar_position lsbp_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_lsbp_checker (.*);
